FILE: rtl/gcd_pkg.sv
// Shared constants, types and helpers for the great-circle distance pipeline.
package gcd_pkg;

    localparam int LAT_W        = 24;
    localparam int LON_W        = 25;
    localparam int RAD_W        = 21;
    localparam int DIST_W       = 23;
    localparam int ANG_W        = 24;
    localparam int Q_W          = 31;
    localparam int PROD_W       = 2 * Q_W;
    localparam int CW           = 34;
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int SQRT_IN_W    = 2 * SQRT_STEPS;
    localparam int REM_W        = Q_W + 2;
    localparam int NUM_ANGLES   = 4;

    localparam logic [ANG_W-1:0] DEG90  = 24'd5898240;
    localparam logic [ANG_W-1:0] DEG180 = 24'd11796480;
    localparam logic [26:0]      DEG360 = 27'd23592960;

    localparam logic [Q_W-1:0] ONE_Q30     = 31'd1073741824;
    localparam logic [Q_W-1:0] HALF_PI_Q30 = 31'd1686629713;

    localparam int D2R_W     = 39;
    localparam int D2R_SPLIT = 20;
    localparam logic [D2R_W-1:0]           DEG_TO_RAD = 39'd307041569098;
    localparam logic [D2R_SPLIT-1:0]       D2R_LO     = DEG_TO_RAD[D2R_SPLIT-1:0];
    localparam logic [D2R_W-D2R_SPLIT-1:0] D2R_HI     = DEG_TO_RAD[D2R_W-1:D2R_SPLIT];

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [RAD_W-1:0]  RADIUS_RESET = 21'd1013734;
    localparam logic [DIST_W-1:0] DIST_MAX     = '1;

    localparam int ATAN_TAB [CORDIC_STEPS] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149,
        1048576, 524288, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64,
        32, 16, 8, 4, 2
    };

    typedef struct packed {
        logic valid;
        logic neg;
    } gcd_ctl_t;

    function automatic logic [Q_W-1:0] clamp_q30(input logic signed [CW-1:0] v);
        if (v[CW-1])
            return '0;
        if (v > signed'({3'b000, ONE_Q30}))
            return ONE_Q30;
        return v[Q_W-1:0];
    endfunction

endpackage

FILE: rtl/gcd_if.sv
// Valid/ready channel interfaces for points, distances and radius writes.
interface gcd_point_if
    import gcd_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] first_latitude;
    logic signed [LON_W-1:0] first_longitude;
    logic signed [LAT_W-1:0] second_latitude;
    logic signed [LON_W-1:0] second_longitude;

    modport source (output valid, first_latitude, first_longitude, second_latitude,
                    second_longitude, input ready);
    modport sink   (input valid, first_latitude, first_longitude, second_latitude,
                    second_longitude, output ready);
endinterface

interface gcd_dist_if
    import gcd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;

    modport source (output valid, distance, input ready);
    modport sink   (input valid, distance, output ready);
endinterface

interface gcd_cfg_if
    import gcd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RAD_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/gcd_cordic.sv
// Pipelined CORDIC, one register stage per iteration, rotation or vectoring mode.
module gcd_cordic
    import gcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vectoring,
    input  gcd_ctl_t             ctl_in,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] z_in,
    output gcd_ctl_t             ctl_out,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [CW-1:0] z_out
);

    gcd_ctl_t             ctl_reg [CORDIC_STEPS];
    logic signed [CW-1:0] x_reg   [CORDIC_STEPS];
    logic signed [CW-1:0] y_reg   [CORDIC_STEPS];
    logic signed [CW-1:0] z_reg   [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        gcd_ctl_t             ctl_cur;
        logic signed [CW-1:0] x_cur;
        logic signed [CW-1:0] y_cur;
        logic signed [CW-1:0] z_cur;
        logic signed [CW-1:0] x_sh;
        logic signed [CW-1:0] y_sh;
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;
        logic signed [CW-1:0] z_next;
        logic                 minus;

        if (i == 0)
        begin : g_first
            assign ctl_cur = ctl_in;
            assign x_cur   = x_in;
            assign y_cur   = y_in;
            assign z_cur   = z_in;
        end
        else
        begin : g_rest
            assign ctl_cur = ctl_reg[i-1];
            assign x_cur   = x_reg[i-1];
            assign y_cur   = y_reg[i-1];
            assign z_cur   = z_reg[i-1];
        end

        assign x_sh  = x_cur >>> i;
        assign y_sh  = y_cur >>> i;
        assign minus = vectoring ? y_cur[CW-1] : ~z_cur[CW-1];

        always_comb
        begin
            if (minus)
            begin
                x_next = x_cur - y_sh;
                y_next = y_cur + x_sh;
                z_next = z_cur - CW'(ATAN_TAB[i]);
            end
            else
            begin
                x_next = x_cur + y_sh;
                y_next = y_cur - x_sh;
                z_next = z_cur + CW'(ATAN_TAB[i]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[i] <= '0;
            else if (en)
                ctl_reg[i] <= ctl_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
            end
        end
    end

    assign ctl_out = ctl_reg[CORDIC_STEPS-1];
    assign x_out   = x_reg[CORDIC_STEPS-1];
    assign y_out   = y_reg[CORDIC_STEPS-1];
    assign z_out   = z_reg[CORDIC_STEPS-1];

endmodule

FILE: rtl/great_circle_distance_top.sv
// Haversine great-circle distance pipeline, top level.
// Throughput: one transaction per cycle unless the output stalls; stages are set by the two
// 30-step CORDIC pipelines and the 31-step square-root pipeline.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and sets the radius to 3959.9 miles.
module great_circle_distance_top
    import gcd_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    gcd_point_if.sink   points,
    gcd_dist_if.source  result,
    gcd_cfg_if.sink     cfg
);

    logic             en;
    logic [RAD_W-1:0] radius_reg;

    assign en            = ~result.valid | result.ready;
    assign points.ready  = en;
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else if (cfg.valid)
            radius_reg <= cfg.data;
    end

    // Stage 1: differences and folding
    logic signed [LAT_W:0]   dlat_diff;
    logic [LAT_W:0]          dlat_abs;
    logic [26:0]             dlat_wrap;
    logic signed [LON_W:0]   dlon_diff;
    logic [LON_W:0]          dlon_abs;
    logic signed [26:0]      dlon_wrap;
    logic [26:0]             dlon_wrap_mag;
    logic [LAT_W-1:0]        lat1_abs;
    logic [LAT_W-1:0]        lat2_abs;
    logic                    neg1;
    logic                    neg2;
    logic [ANG_W-1:0]        ang_next [NUM_ANGLES];

    assign dlat_diff = {points.first_latitude[LAT_W-1], points.first_latitude}
                     - {points.second_latitude[LAT_W-1], points.second_latitude};
    assign dlat_abs  = dlat_diff[LAT_W] ? (LAT_W+1)'(0) - dlat_diff : dlat_diff;
    assign dlat_wrap = DEG360 - 27'(dlat_abs);

    assign dlon_diff = {points.first_longitude[LON_W-1], points.first_longitude}
                     - {points.second_longitude[LON_W-1], points.second_longitude};
    assign dlon_abs  = dlon_diff[LON_W] ? (LON_W+1)'(0) - dlon_diff : dlon_diff;
    assign dlon_wrap = signed'(DEG360 - 27'(dlon_abs));
    assign dlon_wrap_mag = dlon_wrap[26] ? 27'(0) - dlon_wrap : dlon_wrap;

    assign lat1_abs = points.first_latitude[LAT_W-1] ? LAT_W'(0) - points.first_latitude
                                                     : points.first_latitude;
    assign lat2_abs = points.second_latitude[LAT_W-1] ? LAT_W'(0) - points.second_latitude
                                                      : points.second_latitude;
    assign neg1 = lat1_abs > DEG90;
    assign neg2 = lat2_abs > DEG90;

    assign ang_next[0] = (dlat_abs > 25'(DEG180)) ? dlat_wrap[ANG_W-1:0] : dlat_abs[ANG_W-1:0];
    assign ang_next[1] = (dlon_abs > 26'(DEG180)) ? dlon_wrap_mag[ANG_W-1:0]
                                                  : dlon_abs[ANG_W-1:0];
    assign ang_next[2] = neg1 ? DEG180 - lat1_abs : lat1_abs;
    assign ang_next[3] = neg2 ? DEG180 - lat2_abs : lat2_abs;

    gcd_ctl_t         s1_ctl_reg;
    logic [ANG_W-1:0] s1_ang_reg [NUM_ANGLES];

    // Stage 2: degree to radian partial products
    gcd_ctl_t                         s2_ctl_reg;
    logic [ANG_W+D2R_SPLIT-1:0]       s2_lo_reg [NUM_ANGLES];
    logic [ANG_W+D2R_W-D2R_SPLIT-1:0] s2_hi_reg [NUM_ANGLES];

    // Stage 3: sum and round to Q30 radians
    logic [62:0]      rad_sum [NUM_ANGLES];
    logic [Q_W-1:0]   rad_next [NUM_ANGLES];
    gcd_ctl_t         s3_ctl_reg;
    logic [Q_W-1:0]   s3_rad_reg [NUM_ANGLES];

    always_comb
    begin
        for (int k = 0; k < NUM_ANGLES; k++)
        begin
            rad_sum[k] = 63'(s2_hi_reg[k]) << D2R_SPLIT;
            rad_sum[k] = rad_sum[k] + 63'(s2_lo_reg[k])
                       + ((k < 2) ? (63'(1) << 30) : (63'(1) << 29));
            rad_next[k] = (k < 2) ? rad_sum[k][61:31] : rad_sum[k][60:30];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
        end
        else if (en)
        begin
            s1_ctl_reg <= '{valid: points.valid, neg: neg1 ^ neg2};
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_ANGLES; k++)
            begin
                s1_ang_reg[k] <= ang_next[k];
                s2_lo_reg[k]  <= s1_ang_reg[k] * D2R_LO;
                s2_hi_reg[k]  <= s1_ang_reg[k] * D2R_HI;
                s3_rad_reg[k] <= rad_next[k];
            end
        end
    end

    // Sine and cosine CORDICs: 0 dlat/2, 1 dlon/2, 2 lat1, 3 lat2
    gcd_ctl_t             rot_ctl;
    logic signed [CW-1:0] rot_x [NUM_ANGLES];
    logic signed [CW-1:0] rot_y [NUM_ANGLES];

    for (genvar k = 0; k < NUM_ANGLES; k++)
    begin : g_rot
        gcd_ctl_t             ctl_o;
        logic signed [CW-1:0] z_o;

        gcd_cordic u_rot (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .vectoring (1'b0),
            .ctl_in    (s3_ctl_reg),
            .x_in      (CORDIC_GAIN),
            .y_in      ('0),
            .z_in      (signed'({3'b000, s3_rad_reg[k]})),
            .ctl_out   (ctl_o),
            .x_out     (rot_x[k]),
            .y_out     (rot_y[k]),
            .z_out     (z_o)
        );

        if (k == 0)
        begin : g_ctl
            assign rot_ctl = ctl_o;
        end
    end

    // Stages 4 to 7: squares, products and a
    gcd_ctl_t          s4_ctl_reg;
    logic [PROD_W-1:0] s4_ss1_reg;
    logic [PROD_W-1:0] s4_ss2_reg;
    logic [PROD_W-1:0] s4_cc_reg;
    gcd_ctl_t          s5_ctl_reg;
    logic [Q_W-1:0]    s5_sin1_reg;
    logic [Q_W-1:0]    s5_sin2_reg;
    logic [Q_W-1:0]    s5_p_reg;
    gcd_ctl_t          s6_ctl_reg;
    logic [Q_W-1:0]    s6_sin1_reg;
    logic [PROD_W-1:0] s6_q_reg;
    gcd_ctl_t          s7_ctl_reg;
    logic [Q_W-1:0]    s7_a_reg;

    logic [Q_W-1:0]    sin1_v;
    logic [Q_W-1:0]    sin2_v;
    logic [Q_W-1:0]    cos1_v;
    logic [Q_W-1:0]    cos2_v;
    logic [PROD_W-1:0] ss1_rnd;
    logic [PROD_W-1:0] ss2_rnd;
    logic [PROD_W-1:0] cc_rnd;
    logic [PROD_W-1:0] q_rnd;
    logic signed [Q_W+1:0] a_sum;
    logic [Q_W-1:0]    a_next;

    assign sin1_v = clamp_q30(rot_y[0]);
    assign sin2_v = clamp_q30(rot_y[1]);
    assign cos1_v = clamp_q30(rot_x[2]);
    assign cos2_v = clamp_q30(rot_x[3]);

    assign ss1_rnd = s4_ss1_reg + (PROD_W'(1) << 29);
    assign ss2_rnd = s4_ss2_reg + (PROD_W'(1) << 29);
    assign cc_rnd  = s4_cc_reg  + (PROD_W'(1) << 29);
    assign q_rnd   = s6_q_reg   + (PROD_W'(1) << 29);

    assign a_sum = s6_ctl_reg.neg ? signed'({2'b00, s6_sin1_reg}) - signed'({2'b00, q_rnd[60:30]})
                                  : signed'({2'b00, s6_sin1_reg}) + signed'({2'b00, q_rnd[60:30]});

    always_comb
    begin
        if (a_sum[Q_W+1])
            a_next = '0;
        else if (a_sum > signed'({2'b00, ONE_Q30}))
            a_next = ONE_Q30;
        else
            a_next = a_sum[Q_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_ctl_reg <= '0;
            s5_ctl_reg <= '0;
            s6_ctl_reg <= '0;
            s7_ctl_reg <= '0;
        end
        else if (en)
        begin
            s4_ctl_reg <= rot_ctl;
            s5_ctl_reg <= s4_ctl_reg;
            s6_ctl_reg <= s5_ctl_reg;
            s7_ctl_reg <= s6_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_ss1_reg  <= sin1_v * sin1_v;
            s4_ss2_reg  <= sin2_v * sin2_v;
            s4_cc_reg   <= cos1_v * cos2_v;
            s5_sin1_reg <= ss1_rnd[60:30];
            s5_sin2_reg <= ss2_rnd[60:30];
            s5_p_reg    <= cc_rnd[60:30];
            s6_sin1_reg <= s5_sin1_reg;
            s6_q_reg    <= s5_p_reg * s5_sin2_reg;
            s7_a_reg    <= a_next;
        end
    end

    // Square roots of a and 1 - a, two radicand bits per stage
    logic [SQRT_IN_W-1:0] sq_in [2];
    logic                 sq_valid_reg [SQRT_STEPS];
    logic [REM_W-1:0]     sq_rem_reg   [2][SQRT_STEPS];
    logic [Q_W-1:0]       sq_root_reg  [2][SQRT_STEPS];
    logic [SQRT_IN_W-1:0] sq_rad_reg   [2][SQRT_STEPS];

    assign sq_in[0] = {1'b0, s7_a_reg, 30'b0};
    assign sq_in[1] = {1'b0, ONE_Q30 - s7_a_reg, 30'b0};

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        logic valid_cur;

        if (j == 0)
        begin : g_first
            assign valid_cur = s7_ctl_reg.valid;
        end
        else
        begin : g_rest
            assign valid_cur = sq_valid_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[j] <= 1'b0;
            else if (en)
                sq_valid_reg[j] <= valid_cur;
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [REM_W-1:0]     rem_cur;
            logic [Q_W-1:0]       root_cur;
            logic [SQRT_IN_W-1:0] rad_cur;
            logic [REM_W+1:0]     trial;
            logic [REM_W+1:0]     test;
            logic [REM_W+1:0]     diff;
            logic                 ge;

            if (j == 0)
            begin : g_first
                assign rem_cur  = '0;
                assign root_cur = '0;
                assign rad_cur  = sq_in[l];
            end
            else
            begin : g_rest
                assign rem_cur  = sq_rem_reg[l][j-1];
                assign root_cur = sq_root_reg[l][j-1];
                assign rad_cur  = sq_rad_reg[l][j-1];
            end

            assign trial = {rem_cur, rad_cur[SQRT_IN_W-1:SQRT_IN_W-2]};
            assign test  = {2'b00, root_cur, 2'b01};
            assign ge    = trial >= test;
            assign diff  = trial - test;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_rem_reg[l][j]  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
                    sq_root_reg[l][j] <= {root_cur[Q_W-2:0], ge};
                    sq_rad_reg[l][j]  <= {rad_cur[SQRT_IN_W-3:0], 2'b00};
                end
            end
        end
    end

    // atan2 vectoring CORDIC
    gcd_ctl_t             vec_ctl;
    logic signed [CW-1:0] vec_x;
    logic signed [CW-1:0] vec_y;
    logic signed [CW-1:0] vec_z;

    gcd_cordic u_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vectoring (1'b1),
        .ctl_in    ('{valid: sq_valid_reg[SQRT_STEPS-1], neg: 1'b0}),
        .x_in      (signed'({3'b000, sq_root_reg[1][SQRT_STEPS-1]})),
        .y_in      (signed'({3'b000, sq_root_reg[0][SQRT_STEPS-1]})),
        .z_in      ('0),
        .ctl_out   (vec_ctl),
        .x_out     (vec_x),
        .y_out     (vec_y),
        .z_out     (vec_z)
    );

    // Final stages: scale by radius, round and saturate
    logic [Q_W-1:0]         ang_clamp;
    logic                   f1_valid_reg;
    logic [RAD_W+Q_W-1:0]   f1_prod_reg;
    logic [RAD_W+Q_W:0]     dist_sum;
    logic [DIST_W-1:0]      dist_next;
    logic                   f2_valid_reg;
    logic [DIST_W-1:0]      f2_dist_reg;

    always_comb
    begin
        if (vec_z[CW-1])
            ang_clamp = '0;
        else if (vec_z > signed'({3'b000, HALF_PI_Q30}))
            ang_clamp = HALF_PI_Q30;
        else
            ang_clamp = vec_z[Q_W-1:0];
    end

    assign dist_sum  = {1'b0, f1_prod_reg} + ((RAD_W+Q_W+1)'(1) << 28);
    assign dist_next = (dist_sum[RAD_W+Q_W:29] > (RAD_W+Q_W-28)'(DIST_MAX))
                     ? DIST_MAX : dist_sum[29+DIST_W-1:29];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= vec_ctl.valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_prod_reg <= radius_reg * ang_clamp;
            f2_dist_reg <= dist_next;
        end
    end

    assign result.valid    = f2_valid_reg;
    assign result.distance = f2_dist_reg;

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !points.ready |-> result.valid)
        else $error("input stalled without a waiting result");

    a_a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        s7_ctl_reg.valid |-> s7_a_reg <= ONE_Q30)
        else $error("haversine term above one");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && f1_valid_reg) |=> $stable(f1_prod_reg) && f1_valid_reg)
        else $error("pipeline advanced during stall");

endmodule

FILE: verif/tb.sv
// Testbench for the great-circle distance pipeline: random handshakes, fixed-point predictor.
module tb;
    import gcd_pkg::*;

    localparam longint DEG90_L    = 5898240;
    localparam longint DEG180_L   = 11796480;
    localparam longint DEG360_L   = 23592960;
    localparam longint ONE_L      = 1073741824;
    localparam longint HALF_PI_L  = 1686629713;
    localparam longint GAIN_L     = 652032874;
    localparam int     LATENCY    = 100;
    localparam int     DRAIN      = LATENCY + 20;
    localparam int     CYCLE_CAP  = 400000;
    localparam int     RAND_ITEMS = 600;

    typedef struct packed {
        logic signed [LAT_W-1:0] lat1;
        logic signed [LON_W-1:0] lon1;
        logic signed [LAT_W-1:0] lat2;
        logic signed [LON_W-1:0] lon2;
    } point_pair_t;

    logic clk;
    logic rst_n;

    gcd_point_if pts();
    gcd_dist_if  res();
    gcd_cfg_if   cfg_ch();

    great_circle_distance_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (pts),
        .result (res),
        .cfg    (cfg_ch)
    );

    logic [DIST_W-1:0] pending_distances[$];
    logic [RAD_W-1:0]  radius_model;
    int                errors = 0;
    int                cycles = 0;
    int                stall_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint fold_deg(input longint d);
        longint m;
        m = (d < 0) ? -d : d;
        m = m % DEG360_L;
        if (m > DEG180_L)
            m = DEG360_L - m;
        return m;
    endfunction

    function automatic longint clamp_one(input longint v);
        if (v < 0)
            return 0;
        if (v > ONE_L)
            return ONE_L;
        return v;
    endfunction

    function automatic void rotate_q30(input longint angle, output longint cosv,
                                       output longint sinv);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = GAIN_L;
        y = 0;
        z = angle;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TAB[i]);
            end
        end
        cosv = clamp_one(x);
        sinv = clamp_one(y);
    endfunction

    function automatic longint half_sin_squared(input longint d);
        longint unsigned t;
        longint          rad;
        longint          c;
        longint          s;
        t   = longint'(fold_deg(d));
        rad = longint'((t * longint'(DEG_TO_RAD) + (64'd1 << 30)) >> 31);
        rotate_q30(rad, c, s);
        return longint'((longint'(s) * s + (64'd1 << 29)) >> 30);
    endfunction

    function automatic longint cos_magnitude(input longint d, output bit neg);
        longint unsigned t;
        longint          rad;
        longint          c;
        longint          s;
        t   = longint'(fold_deg(d));
        neg = (t > DEG90_L);
        if (neg)
            t = DEG180_L - t;
        rad = longint'((t * longint'(DEG_TO_RAD) + (64'd1 << 29)) >> 30);
        rotate_q30(rad, c, s);
        return c;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint central_angle(input longint y, input longint x);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TAB[i]);
            end
        end
        if (z < 0)
            z = 0;
        if (z > HALF_PI_L)
            z = HALF_PI_L;
        return z;
    endfunction

    function automatic logic [DIST_W-1:0] predict_distance(input point_pair_t pp,
                                                           input logic [RAD_W-1:0] radius);
        longint          lat1;
        longint          lon1;
        longint          lat2;
        longint          lon2;
        longint          dlat;
        longint          dlon;
        longint          s1;
        longint          s2;
        longint          c1;
        longint          c2;
        longint          p;
        longint          q;
        longint          a;
        longint          z;
        longint unsigned sa;
        longint unsigned ca;
        longint unsigned d;
        bit              n1;
        bit              n2;
        lat1 = pp.lat1;
        lon1 = pp.lon1;
        lat2 = pp.lat2;
        lon2 = pp.lon2;
        dlat = lat1 - lat2;
        dlon = lon1 - lon2;
        if (dlat < 0)
            dlat = -dlat;
        if (dlon < 0)
            dlon = -dlon;
        if (dlon > DEG180_L)
            dlon = DEG360_L - dlon;
        s1 = half_sin_squared(dlat);
        s2 = half_sin_squared(dlon);
        c1 = cos_magnitude(lat1, n1);
        c2 = cos_magnitude(lat2, n2);
        p  = (c1 * c2 + (64'd1 << 29)) >>> 30;
        q  = (p * s2 + (64'd1 << 29)) >>> 30;
        a  = (n1 != n2) ? s1 - q : s1 + q;
        a  = clamp_one(a);
        sa = int_sqrt(longint'(a) << 30);
        ca = int_sqrt(longint'(ONE_L - a) << 30);
        z  = central_angle(longint'(sa), longint'(ca));
        d  = (longint'(radius) * z + (64'd1 << 28)) >> 29;
        if (d > 64'd8388607)
            d = 64'd8388607;
        return d[DIST_W-1:0];
    endfunction

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_points(input point_pair_t pp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pts.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pts.valid            <= 1'b1;
        pts.first_latitude   <= pp.lat1;
        pts.first_longitude  <= pp.lon1;
        pts.second_latitude  <= pp.lat2;
        pts.second_longitude <= pp.lon2;
        do
            @(posedge clk);
        while (!pts.ready);
        pending_distances.push_back(predict_distance(pp, radius_model));
    endtask

    task automatic wait_idle();
        pts.valid <= 1'b0;
        while (pending_distances.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_radius(input logic [RAD_W-1:0] value);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        radius_model = value;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic point_pair_t make_pair(input longint lat1, input longint lon1,
                                              input longint lat2, input longint lon2);
        point_pair_t pp;
        pp.lat1 = lat1[LAT_W-1:0];
        pp.lon1 = lon1[LON_W-1:0];
        pp.lat2 = lat2[LAT_W-1:0];
        pp.lon2 = lon2[LON_W-1:0];
        return pp;
    endfunction

    function automatic point_pair_t random_pair();
        point_pair_t pp;
        if ($urandom_range(0, 9) < 8)
        begin
            pp.lat1 = LAT_W'($urandom_range(0, 2 * DEG90_L) - DEG90_L);
            pp.lon1 = LON_W'($urandom_range(0, 2 * DEG180_L) - DEG180_L);
            pp.lat2 = LAT_W'($urandom_range(0, 2 * DEG90_L) - DEG90_L);
            pp.lon2 = LON_W'($urandom_range(0, 2 * DEG180_L) - DEG180_L);
        end
        else
        begin
            pp.lat1 = LAT_W'($urandom());
            pp.lon1 = LON_W'($urandom());
            pp.lat2 = LAT_W'($urandom());
            pp.lon2 = LON_W'($urandom());
        end
        return pp;
    endfunction

    task automatic test_directed_points();
        send_points(make_pair(0, 0, 0, 0));
        send_points(make_pair(DEG90_L, 0, -DEG90_L, 0));
        send_points(make_pair(0, 0, 0, DEG180_L));
        send_points(make_pair(0, -DEG180_L, 0, DEG180_L));
        send_points(make_pair(0, DEG180_L - 65536, 0, -DEG180_L + 65536));
        send_points(make_pair(DEG90_L, DEG180_L, DEG90_L, -DEG180_L));
        send_points(make_pair(-DEG90_L, 100, DEG90_L, -100));
        send_points(make_pair(2621440, -7864320, 3276800, 5242880));
        send_points(make_pair(-8388608, -16777216, 8388607, 16777215));
        send_points(make_pair(8388607, 16777215, -8388608, -16777216));
        send_points(make_pair(-8388608, 16777215, -8388608, -16777216));
        send_points(make_pair(7000000, 0, -7000000, 0));
        send_points(make_pair(0, 0, 1, 1));
        send_points(make_pair(-1, -1, 0, 0));
        send_points(make_pair(DEG90_L, 0, DEG90_L, 1000000));
        send_points(make_pair(3000000, 3000000, -3000000, -3000000 + DEG180_L));
    endtask

    task automatic test_radius_extremes();
        write_radius('1);
        send_points(make_pair(DEG90_L, 0, -DEG90_L, 0));
        send_points(make_pair(0, 0, 0, DEG180_L));
        for (int i = 0; i < 10; i++)
            send_points(random_pair());
        write_radius('0);
        send_points(make_pair(DEG90_L, 0, -DEG90_L, 0));
        for (int i = 0; i < 10; i++)
            send_points(random_pair());
        write_radius(21'd1);
        for (int i = 0; i < 10; i++)
            send_points(random_pair());
    endtask

    task automatic test_random_points();
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 150 == 0)
                write_radius(RAD_W'($urandom_range(0, (1 << RAD_W) - 1)));
            send_points(random_pair());
        end
        write_radius(RADIUS_RESET);
        for (int i = 0; i < 30; i++)
            send_points(random_pair());
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res.ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (pending_distances.size() == 0)
                    report($sformatf("unexpected distance %0d", res.distance));
                else if (res.distance !== pending_distances[0])
                begin
                    report($sformatf("distance %0d, want %0d", res.distance,
                                     pending_distances[0]));
                    void'(pending_distances.pop_front());
                end
                else
                    void'(pending_distances.pop_front());
            end
            if (stall_left > 0)
            begin
                res.ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                res.ready  <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("[great_circle_distance_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        radius_model         = RADIUS_RESET;
        rst_n                <= 1'b0;
        pts.valid            <= 1'b0;
        pts.first_latitude   <= '0;
        pts.first_longitude  <= '0;
        pts.second_latitude  <= '0;
        pts.second_longitude <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.data          <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_points();
        test_radius_extremes();
        test_random_points();
        wait_idle();
        if (errors == 0)
            $display("[great_circle_distance_top] OK");
        else
            $display("[great_circle_distance_top] ERROR");
        $finish;
    end

endmodule
